// ===== rtl/core/mmts_pkg.sv =====
// ----------------------------------------------------------------------------
// mmts_pkg: shared types and constants
// Constants and the hand-off types that travel between the threshold cells
// of the max-min-times-sum interval block.
// ----------------------------------------------------------------------------
package mmts_pkg;

    // Default ranges of the element values and of the sequence length.
    localparam int MAX_VALUE_DEF = 100;
    localparam int MAX_LEN_DEF   = 4096;

    // Fixed widths of the request and result fields.
    localparam int VALUE_W = 7;
    localparam int PROD_W  = 26;

    // Largest reportable product; bigger products saturate to this.
    localparam logic [PROD_W-1:0] PROD_MAX = '1;

    // Control that moves with each element from one cell to the next.
    typedef struct packed {
        logic valid;
        logic last;
    } ctl_t;

    // Running maximum handed down the row when a sequence closes.
    typedef struct packed {
        logic              valid;
        logic [PROD_W-1:0] best;
    } acc_t;

endpackage

// ===== rtl/core/mmts_cell.sv =====
// ----------------------------------------------------------------------------
// mmts_cell: one threshold cell
// Tracks the open run of elements at or above its threshold, folds closed
// runs into a local best, and merges that best into the passing result.
// ----------------------------------------------------------------------------
module mmts_cell #(
    parameter int MAX_VALUE = mmts_pkg::MAX_VALUE_DEF,
    parameter int MAX_LEN   = mmts_pkg::MAX_LEN_DEF,
    parameter int THRESH    = 1,
    localparam int VAL_W    = $clog2(MAX_VALUE + 2)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  mmts_pkg::ctl_t     ctl_in,
    input  logic [VAL_W-1:0]   val_in,
    input  mmts_pkg::acc_t     acc_in,
    output mmts_pkg::ctl_t     ctl_out,
    output logic [VAL_W-1:0]   val_out,
    output mmts_pkg::acc_t     acc_out
);
    import mmts_pkg::*;

    localparam int SUM_BOUND = MAX_LEN * MAX_VALUE;
    localparam int SUM_W     = $clog2(SUM_BOUND + 1);
    localparam int MUL_W     = SUM_W + VAL_W;
    localparam int WIDE_W    = (MUL_W > PROD_W) ? MUL_W : PROD_W;

    localparam logic [VAL_W-1:0] EMPTY_MIN = VAL_W'(MAX_VALUE + 1);
    localparam logic [VAL_W-1:0] THR       = VAL_W'(THRESH);

    // Run state and forwarded element.
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [VAL_W-1:0] min_reg, min_next;
    ctl_t             ctl_reg;
    logic [VAL_W-1:0] val_reg;

    // Closed run waiting for its product.
    logic             b_valid_reg, b_close_reg, b_last_reg;
    logic [SUM_W-1:0] close_sum_reg;
    logic [VAL_W-1:0] close_min_reg;

    // Local best and the result handed on.
    logic [PROD_W-1:0] best_reg, best_next;
    acc_t              acc_reg, acc_next;

    logic             take;
    logic             close;
    logic [SUM_W:0]   sum_add;
    logic [SUM_W-1:0] upd_sum;
    logic [VAL_W-1:0] upd_min;
    logic [WIDE_W-1:0] prod_wide;
    logic [PROD_W-1:0] prod_sat;
    logic [PROD_W-1:0] best_cand;

    // The element extends the run when it reaches the threshold; otherwise it
    // ends the run. The last element of a sequence ends every run.
    always_comb begin
        take    = (val_in >= THR);
        close   = !take || ctl_in.last;
        sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(val_in);
        upd_sum = sum_reg;
        upd_min = min_reg;
        if (take) begin
            if (sum_add > (SUM_W + 1)'(SUM_BOUND)) begin
                upd_sum = SUM_W'(SUM_BOUND);
            end else begin
                upd_sum = sum_add[SUM_W-1:0];
            end
            if (val_in < min_reg) begin
                upd_min = val_in;
            end
        end
        if (close) begin
            sum_next = '0;
            min_next = EMPTY_MIN;
        end else begin
            sum_next = upd_sum;
            min_next = upd_min;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            min_reg       <= EMPTY_MIN;
            ctl_reg       <= '0;
            b_valid_reg   <= 1'b0;
            b_close_reg   <= 1'b0;
            b_last_reg    <= 1'b0;
        end else if (en) begin
            ctl_reg     <= ctl_in;
            b_valid_reg <= ctl_in.valid;
            b_close_reg <= close;
            b_last_reg  <= ctl_in.last;
            if (ctl_in.valid) begin
                sum_reg <= sum_next;
                min_reg <= min_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val_reg       <= val_in;
            close_sum_reg <= upd_sum;
            close_min_reg <= upd_min;
        end
    end

    // Product of the closed run; an empty run has a zero sum.
    always_comb begin
        prod_wide = WIDE_W'(close_sum_reg) * WIDE_W'(close_min_reg);
        if (prod_wide > WIDE_W'(PROD_MAX)) begin
            prod_sat = PROD_MAX;
        end else begin
            prod_sat = PROD_W'(prod_wide);
        end
        best_cand = best_reg;
        if (b_valid_reg && b_close_reg && (prod_sat > best_reg)) begin
            best_cand = prod_sat;
        end
        acc_next       = '0;
        best_next      = best_cand;
        if (b_valid_reg && b_last_reg) begin
            acc_next.valid = 1'b1;
            acc_next.best  = (acc_in.best > best_cand) ? acc_in.best : best_cand;
            best_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg      <= '0;
            acc_reg.valid <= 1'b0;
        end else if (en) begin
            best_reg      <= best_next;
            acc_reg       <= acc_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign val_out = val_reg;
    assign acc_out = acc_reg;

    // An open run always holds at least one element at or above the threshold.
    a_min_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (min_reg == EMPTY_MIN) || ((min_reg >= THR) && (min_reg < EMPTY_MIN)))
        else $error("run minimum out of range");

    // The run sum is zero exactly when the run is empty.
    a_sum_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (sum_reg == '0) == (min_reg == EMPTY_MIN))
        else $error("run sum and minimum disagree");

    // A closing sequence meets the result from the previous cell in step.
    a_acc_align: assert property (@(posedge aclk) disable iff (!aresetn)
        ((THRESH > 1) && b_valid_reg && b_last_reg) |-> acc_in.valid)
        else $error("result chain out of step");

endmodule

// ===== rtl/core/max_min_times_sum_interval.sv =====
// ----------------------------------------------------------------------------
// max_min_times_sum_interval: max over intervals of minimum times sum
// A row of threshold cells computes, per sequence, the greatest product of
// interval minimum and interval sum, and reports it on the last element.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                          Moves
//  -------  -----------------------------  ---------------------------------
//  s_       s_valid s_ready s_value s_last  one element request per handshake
//  m_       m_valid m_ready m_best_product  one result per closed sequence
//
// Flow: one element request is taken every clock cycle while s_ready is high.
// The element walks the row of MAX_VALUE threshold cells, one cell per cycle
// while the row moves; each cell registers the closed run, then its merged
// result, and the output register then shows the result on m_valid.
// Reset: aresetn is synchronous and active low; it empties the row, clears
// every run and best, and drops m_valid. No clearing pass follows.
// Stalls: the output register holds one result. The whole row halts only when
// a new result reaches the end of the row while the output register still
// holds a result that is not taken; s_ready is low for exactly those cycles.
//
module max_min_times_sum_interval #(
    parameter int MAX_VALUE = mmts_pkg::MAX_VALUE_DEF,
    parameter int MAX_LEN   = mmts_pkg::MAX_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mmts_pkg::VALUE_W-1:0]  s_value,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mmts_pkg::PROD_W-1:0]   m_best_product
);
    import mmts_pkg::*;

    localparam int VAL_W = $clog2(MAX_VALUE + 2);

    // Hand-off wires between cells; index 0 feeds the first cell.
    ctl_t             ctl [0:MAX_VALUE];
    logic [VAL_W-1:0] val [0:MAX_VALUE];
    acc_t             acc [0:MAX_VALUE];

    logic             en;
    logic [VAL_W-1:0] sat_value;

    logic              m_valid_reg;
    logic [PROD_W-1:0] m_best_reg;

    // Values above the range count as the largest value.
    always_comb begin
        if (int'(s_value) > MAX_VALUE) begin
            sat_value = VAL_W'(MAX_VALUE);
        end else begin
            sat_value = VAL_W'(s_value);
        end
    end

    // The row moves as one; it only waits when a finished result would
    // otherwise overwrite one that is still held at the output.
    assign en      = !(acc[MAX_VALUE].valid && m_valid_reg && !m_ready);
    assign s_ready = en;

    assign ctl[0]       = '{valid: s_valid, last: s_last};
    assign val[0]       = sat_value;
    assign acc[0]       = '0;

    // Cell g watches the runs of elements at or above g + 1.
    for (genvar g = 0; g < MAX_VALUE; g++) begin : g_cell
        mmts_cell #(
            .MAX_VALUE (MAX_VALUE),
            .MAX_LEN   (MAX_LEN),
            .THRESH    (g + 1)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (ctl[g]),
            .val_in  (val[g]),
            .acc_in  (acc[g]),
            .ctl_out (ctl[g+1]),
            .val_out (val[g+1]),
            .acc_out (acc[g+1])
        );
    end

    // Output register: loads a result as it leaves the row, drops when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en && acc[MAX_VALUE].valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && acc[MAX_VALUE].valid) begin
            m_best_reg <= acc[MAX_VALUE].best;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_best_product = m_best_reg;

    // While the row waits, the first cell keeps what it holds.
    a_hold_row: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(ctl[1]) && $stable(val[1]))
        else $error("row moved during a stall");

    // A result leaving the row is never lost: it lands in the output register.
    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && acc[MAX_VALUE].valid) |=> m_valid && (m_best_product == $past(acc[MAX_VALUE].best)))
        else $error("result dropped at the output");

    // The row only waits while a result is held and a new one is ready.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && acc[MAX_VALUE].valid))
        else $error("row stalled without cause");

endmodule
